### rtl/core/tlvp_pkg.sv
// Shared types and constants for the telemetry TLV packet parser.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlvp_pkg;

   // Datagram constants
   localparam logic [31:0] MAGIC_WORD     = 32'h5566_7788;
   localparam logic [15:0] TAG_DEMO       = 16'd0;
   localparam logic [15:0] TAG_VISION     = 16'd16;
   localparam logic [2:0]  VISION_COLUMNS = 3'd6;
   localparam logic [3:0]  DEMO_WORDS     = 4'd9;

   // Record kinds
   localparam logic [4:0] KIND_STATE       = 5'd0;
   localparam logic [4:0] KIND_SEQ         = 5'd1;
   localparam logic [4:0] KIND_DEMO_BASE   = 5'd2;
   localparam logic [4:0] KIND_COUNT       = 5'd11;
   localparam logic [4:0] KIND_COLUMN_BASE = 5'd12;
   localparam logic [4:0] KIND_STATUS      = 5'd18;

   // Status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_HEADER = 2'd1;
   localparam logic [1:0] ST_ZERO_LEN   = 2'd2;
   localparam logic [1:0] ST_TRUNCATED  = 2'd3;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_STATE,
      PH_SEQ,
      PH_RESERVED,
      PH_OPT_HEAD,
      PH_OPT_BODY,
      PH_DRAIN
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  record_kind;
      logic [1:0]  tag_index;
      logic [31:0] field_value;
      logic        last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [1:0]  idx;
      logic [31:0] value;
   } record_type;

   // All records caused by one byte; rec1 is used only when two is set
   typedef struct packed {
      logic       two;
      record_type rec0;
      record_type rec1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

`default_nettype wire

### rtl/core/tlvp_front.sv
// Front end: accepts datagram bytes, assembles words and walks options.
// Produces one queue entry per byte that causes records. Depends on tlvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_front #(
   parameter int MAX_TAGS = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire tlvp_pkg::req_payload_type req_data,
   output logic                          push,
   output tlvp_pkg::entry_type           push_entry
);
   import tlvp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  biw_ff, biw_in;
   logic [23:0] asm_ff, asm_in;
   logic [15:0] kind_ff, kind_in;
   logic [15:0] left_ff, left_in;
   logic [3:0]  wio_ff, wio_in;
   logic [31:0] count_ff, count_in;
   logic [15:0] row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   logic [1:0]  status_ff, status_in;

   logic        full;
   logic [31:0] word;
   logic [15:0] row_inc;
   logic        main_valid;
   record_type  main_rec;
   record_type  status_rec;
   logic [1:0]  final_status;

   // Hold parser state; advance only on a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         biw_ff    <= '0;
         asm_ff    <= '0;
         kind_ff   <= '0;
         left_ff   <= '0;
         wio_ff    <= '0;
         count_ff  <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         status_ff <= ST_OK;
      end else if (accept) begin
         phase_ff  <= phase_in;
         biw_ff    <= biw_in;
         asm_ff    <= asm_in;
         kind_ff   <= kind_in;
         left_ff   <= left_in;
         wio_ff    <= wio_in;
         count_ff  <= count_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         status_ff <= status_in;
      end
   end

   // Next state and records for the byte on the input
   always_comb begin
      phase_in     = phase_ff;
      biw_in       = biw_ff;
      asm_in       = asm_ff;
      kind_in      = kind_ff;
      left_in      = left_ff;
      wio_in       = wio_ff;
      count_in     = count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      status_in    = status_ff;
      main_valid   = 1'b0;
      main_rec     = '0;
      full         = (biw_ff == 2'd3);
      word         = {req_data.data_byte, asm_ff};
      row_inc      = row_ff + 16'd1;
      final_status = ST_OK;

      if (phase_ff != PH_DRAIN) begin
         // Gather the byte into the word under assembly
         biw_in = biw_ff + 2'd1;
         case (biw_ff)
            2'd0:    asm_in[7:0]   = req_data.data_byte;
            2'd1:    asm_in[15:8]  = req_data.data_byte;
            2'd2:    asm_in[23:16] = req_data.data_byte;
            default: asm_in        = '0;
         endcase

         case (phase_ff)
            PH_HEADER: begin
               if (full) begin
                  if (word != MAGIC_WORD) begin
                     status_in = ST_BAD_HEADER;
                     phase_in  = PH_DRAIN;
                  end else begin
                     phase_in = PH_STATE;
                  end
               end
            end
            PH_STATE: begin
               if (full) begin
                  main_valid = 1'b1;
                  main_rec   = '{kind: KIND_STATE, idx: 2'd0, value: word};
                  phase_in   = PH_SEQ;
               end
            end
            PH_SEQ: begin
               if (full) begin
                  main_valid = 1'b1;
                  main_rec   = '{kind: KIND_SEQ, idx: 2'd0, value: word};
                  phase_in   = PH_RESERVED;
               end
            end
            PH_RESERVED: begin
               if (full) phase_in = PH_OPT_HEAD;
            end
            PH_OPT_HEAD: begin
               if (full) begin
                  kind_in = word[15:0];
                  if (word[31:16] < 16'd4) begin
                     status_in = ST_ZERO_LEN;
                     phase_in  = PH_DRAIN;
                  end else begin
                     left_in = word[31:16] - 16'd4;
                     wio_in  = '0;
                     if (word[31:16] != 16'd4) phase_in = PH_OPT_BODY;
                  end
               end
            end
            PH_OPT_BODY: begin
               if (full) begin
                  if (kind_ff == TAG_DEMO) begin
                     if (wio_ff == 4'd0) begin
                        main_valid = 1'b1;
                        main_rec   = '{kind: KIND_DEMO_BASE, idx: 2'd0,
                                       value: {{16{word[31]}}, word[31:16]}};
                     end else if (wio_ff < DEMO_WORDS) begin
                        main_valid = 1'b1;
                        main_rec   = '{kind: KIND_DEMO_BASE + {1'b0, wio_ff}, idx: 2'd0,
                                       value: word};
                     end
                  end else if (kind_ff == TAG_VISION) begin
                     if (wio_ff == 4'd0) begin
                        count_in   = word;
                        row_in     = '0;
                        col_in     = '0;
                        main_valid = 1'b1;
                        main_rec   = '{kind: KIND_COUNT, idx: 2'd0, value: word};
                     end else if (count_ff != 32'd0 && !count_ff[31] &&
                                  col_ff < VISION_COLUMNS) begin
                        if (row_ff < 16'(MAX_TAGS)) begin
                           main_valid = 1'b1;
                           main_rec   = '{kind: KIND_COLUMN_BASE + {2'b00, col_ff},
                                          idx: row_ff[1:0], value: word};
                        end
                        row_in = row_inc;
                        if ({16'd0, row_inc} == count_ff) begin
                           row_in = '0;
                           col_in = col_ff + 3'd1;
                        end
                     end
                  end
                  // Saturate the word counter; only zero and below nine matter
                  if (wio_ff != 4'hF) wio_in = wio_ff + 4'd1;
               end
               if (left_ff != 16'd0) left_in = left_ff - 16'd1;
               if (left_ff <= 16'd1) begin
                  biw_in   = '0;
                  asm_in   = '0;
                  phase_in = PH_OPT_HEAD;
               end
            end
            default: ;
         endcase
      end

      // Close the datagram: status record, then back to reset state
      if (req_data.end_of_datagram) begin
         final_status = status_in;
         if (status_in == ST_OK && !(phase_in == PH_OPT_HEAD && biw_in == 2'd0))
            final_status = ST_TRUNCATED;
         phase_in  = PH_HEADER;
         biw_in    = '0;
         asm_in    = '0;
         kind_in   = '0;
         left_in   = '0;
         wio_in    = '0;
         count_in  = '0;
         row_in    = '0;
         col_in    = '0;
         status_in = ST_OK;
      end
   end

   // Pack the records of this byte into one queue entry
   always_comb begin
      status_rec = '{kind: KIND_STATUS, idx: 2'd0, value: {30'd0, final_status}};
      push_entry = '0;
      if (main_valid) begin
         push_entry.two  = req_data.end_of_datagram;
         push_entry.rec0 = main_rec;
         push_entry.rec1 = status_rec;
      end else begin
         push_entry.rec0 = status_rec;
      end
      push = accept && (main_valid || req_data.end_of_datagram);
   end

endmodule

`default_nettype wire

### rtl/core/tlvp_queue.sv
// Short queue of record entries between the parser front and output back.
// Depends on tlvp_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire tlvp_pkg::entry_type push_entry,
   input  wire logic                pop,
   output tlvp_pkg::entry_type      head,
   output tlvp_pkg::qstat_type      qstat
);
   import tlvp_pkg::*;

   entry_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

   assign head            = mem_ff[rd_ff];
   assign qstat.full      = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign qstat.not_empty = (cnt_ff != '0);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !qstat.not_empty |-> !pop)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QDEPTH))
      else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + (QPTR_W+1)'(1)))
      else $error("queue count did not follow push");

endmodule

`default_nettype wire

### rtl/core/tlvp_back.sv
// Back end: takes queue entries and presents their records one per cycle
// while rsp_ready is high, from an output register. Depends on tlvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tlvp_pkg::entry_type head,
   input  wire tlvp_pkg::qstat_type qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output tlvp_pkg::rsp_payload_type rsp_payload
);
   import tlvp_pkg::*;

   entry_type hold_ff, hold_in;
   logic      valid_ff, valid_in;
   logic      sel_ff, sel_in;
   logic      last_shown;
   record_type cur;

   // Pick the record on show and whether it closes its entry
   always_comb begin
      last_shown = sel_ff || !hold_ff.two;
      cur        = sel_ff ? hold_ff.rec1 : hold_ff.rec0;
   end

   // Load the next entry when empty or once the current one is fully transferred
   always_comb begin
      pop      = 1'b0;
      hold_in  = hold_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (!valid_ff || (rsp_ready && last_shown)) begin
         if (qstat.not_empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            hold_in  = head;
            sel_in   = 1'b0;
         end else begin
            valid_in = 1'b0;
         end
      end else if (rsp_ready) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign rsp_valid               = valid_ff;
   assign rsp_payload.record_kind = cur.kind;
   assign rsp_payload.tag_index   = cur.idx;
   assign rsp_payload.field_value = cur.value;
   assign rsp_payload.last_of_run = last_shown;

endmodule

`default_nettype wire

### rtl/core/telemetry_tlv_packet_parser_core.sv
// Telemetry TLV packet parser: top level.
// Instantiates tlvp_front, tlvp_queue and tlvp_back; types from tlvp_pkg.
//
// Usage:
//   req_ channel carries one datagram byte per transfer, with end_of_datagram
//   set on the final byte. rsp_ channel carries result records: header words,
//   demo fields, vision count and tag columns, and a status record that closes
//   each datagram. last_of_run marks the final record caused by a byte.
//   Throughput: one byte per cycle while the queue has room. A byte that
//   causes two records (a data word on the final byte plus the status)
//   occupies the output until both transfer; the output register shows one
//   record per cycle while rsp_ready is high. A record's entry is enqueued by
//   the front at its byte's transfer edge, then loaded by the back into its
//   output register, from which it is presented on rsp_.
//   A four-entry queue between the front and back lets req_ keep flowing
//   while rsp_ stalls; req_ready drops only when that queue is full.
//   Reset (synchronous, active high) returns the parser to expecting a header
//   and empties the queue and output register; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_tlv_packet_parser_core #(
   parameter int MAX_TAGS = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire tlvp_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output tlvp_pkg::rsp_payload_type      rsp_payload
);
   import tlvp_pkg::*;

   logic      accept;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;
   qstat_type qstat;

   // Take a byte whenever the queue has room
   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;

   tlvp_front #(
      .MAX_TAGS(MAX_TAGS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_payload),
      .push       (push),
      .push_entry (push_entry)
   );

   tlvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   tlvp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
